### hw/rtl/xms_pkg.sv
// Shared types, codes and segment classification for the XML markup segmenter.
`default_nettype none

package xms_pkg;

    // Segment kinds as reported on the result channel
    typedef enum logic [2:0] {
        KIND_TEXT    = 3'd0,
        KIND_START   = 3'd1,
        KIND_END     = 3'd2,
        KIND_EMPTY   = 3'd3,
        KIND_COMMENT = 3'd4,
        KIND_DECL    = 3'd5,
        KIND_PI      = 3'd6,
        KIND_ERROR   = 3'd7
    } seg_kind_t;

    // Syntax error codes
    typedef enum logic [3:0] {
        ERR_NONE          = 4'd0,
        ERR_BAD_CHAR      = 4'd1,
        ERR_STRAY_GT      = 4'd2,
        ERR_STRAY_LT      = 4'd3,
        ERR_UNMATCHED_END = 4'd4,
        ERR_DECL_NESTED   = 4'd5,
        ERR_DECL_NOT_1ST  = 4'd6,
        ERR_INVALID_TAG   = 4'd7,
        ERR_MISSING_CLOSE = 4'd8,
        ERR_TOO_DEEP      = 4'd9
    } err_code_t;

    localparam int unsigned MAX_DEPTH_DEF = 255;
    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    // Byte values of interest
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_NEL   = 8'h85;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Head patterns, first byte in the low bits
    localparam logic [31:0] HEAD_CMT  = 32'h2D2D213C;      // "<!--"
    localparam logic [47:0] HEAD_DECL = 48'h206C6D783F3C;  // "<?xml "
    localparam logic [15:0] HEAD_PI   = 16'h3F3C;          // "<?"
    localparam logic [15:0] HEAD_ETAG = 16'h2F3C;          // "</"
    // Tail patterns, newest byte in the low bits
    localparam logic [23:0] TAIL_CMT  = 24'h2D2D3E;        // "-->"
    localparam logic [15:0] TAIL_PI   = 16'h3F3E;          // "?>"
    localparam logic [15:0] TAIL_EMPTY = 16'h2F3E;         // "/>"

    // One result
    typedef struct packed {
        logic [2:0]  seg_kind;
        logic [3:0]  error_code;
        logic [15:0] seg_length;
        logic [7:0]  depth_after;
        logic        last_result;
    } res_t;

    // Results produced by one request
    typedef struct packed {
        logic [1:0] count;
        res_t       first;
        res_t       second;
    } step_out_t;

    // Outcome of closing a markup segment
    typedef struct packed {
        seg_kind_t  kind;
        err_code_t  code;
        logic [7:0] depth;
        logic       root;
    } fin_t;

    function automatic res_t mk_res(seg_kind_t kind, err_code_t code,
                                    logic [15:0] len, logic [7:0] depth);
        res_t r;
        r.seg_kind    = kind;
        r.error_code  = code;
        r.seg_length  = len;
        r.depth_after = depth;
        r.last_result = 1'b0;
        return r;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF) ||
               (c == CH_NEL);
    endfunction

    // Classify a closed markup segment and apply its effect on depth and root
    function automatic fin_t finish_markup(logic [15:0] n, logic [47:0] head,
                                           logic [23:0] tail, logic [7:0] depth,
                                           logic root, logic [7:0] limit);
        fin_t f;
        f.kind  = KIND_ERROR;
        f.code  = ERR_NONE;
        f.depth = depth;
        f.root  = root;
        if (n >= 16'd7 && head[31:0] == HEAD_CMT && tail == TAIL_CMT)
            f.kind = KIND_COMMENT;
        else if (n >= 16'd7 && head == HEAD_DECL && tail[15:0] == TAIL_PI)
            f.kind = KIND_DECL;
        else if (n >= 16'd4 && head[15:0] == HEAD_PI && tail[15:0] == TAIL_PI)
            f.kind = KIND_PI;
        else if (n >= 16'd3 && head[7:0] == CH_LT && tail[15:0] == TAIL_EMPTY)
            f.kind = KIND_EMPTY;
        else if (n >= 16'd3 && head[15:0] == HEAD_ETAG && tail[7:0] == CH_GT)
            f.kind = KIND_END;
        else if (n >= 16'd2 && head[7:0] == CH_LT && tail[7:0] == CH_GT)
            f.kind = KIND_START;
        else
            f.code = ERR_INVALID_TAG;

        case (f.kind)
            KIND_START:
            begin
                if (depth >= limit)
                    f.code = ERR_TOO_DEEP;
                else
                begin
                    if (depth == 8'd0)
                        f.root = 1'b1;
                    f.depth = depth + 8'd1;
                end
            end
            KIND_END:
            begin
                if (depth == 8'd0)
                    f.code = ERR_UNMATCHED_END;
                else
                    f.depth = depth - 8'd1;
            end
            KIND_DECL:
            begin
                if (depth != 8'd0)
                    f.code = ERR_DECL_NESTED;
                else if (root)
                    f.code = ERR_DECL_NOT_1ST;
            end
            KIND_COMMENT, KIND_EMPTY, KIND_PI:
            begin
                if (depth == 8'd0)
                    f.root = 1'b1;
            end
            default:
            begin
                f.root = root;
            end
        endcase

        // An error reports the depth that was in force
        if (f.code != ERR_NONE)
        begin
            f.kind  = KIND_ERROR;
            f.depth = depth;
            f.root  = root;
        end
        return f;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/xms_ifs.sv
// Request and result channel interfaces of the XML markup segmenter.
`default_nettype none

interface xms_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface xms_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  seg_kind;
    logic [3:0]  error_code;
    logic [15:0] seg_length;
    logic [7:0]  depth_after;
    logic        last_result;

    modport source (output valid, output seg_kind, output error_code, output seg_length,
                    output depth_after, output last_result, input ready);
    modport sink   (input valid, input seg_kind, input error_code, input seg_length,
                    input depth_after, input last_result, output ready);
endinterface

`default_nettype wire

### hw/rtl/xms_core.sv
// Segmenter state and per-byte update: classifies segments and emits up to two results.
`default_nettype none

module xms_core #(
    parameter int unsigned MAX_DEPTH = xms_pkg::MAX_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire logic             req_type,
    input  wire logic [7:0]       data_byte,
    output xms_pkg::step_out_t    step_out
);
    import xms_pkg::*;

    localparam logic [7:0] DEPTH_LIMIT = (MAX_DEPTH > 255) ? 8'd255 : 8'(MAX_DEPTH);

    logic        markup_reg, markup_next;
    logic        comment_reg, comment_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [47:0] head_reg, head_next;
    logic [23:0] tail_reg, tail_next;
    logic        saw_reg, saw_next;
    logic [7:0]  depth_reg, depth_next;
    logic        root_reg, root_next;
    logic        halt_reg, halt_next;

    logic [7:0]  c_eff;
    logic [15:0] cnt_p;
    logic [47:0] head_p;
    logic [23:0] tail_p;
    logic        comment_p;
    logic        halt_tmp;
    fin_t        fin;
    res_t        res_a, res_b;
    logic [1:0]  n_res;

    // Segment buffer with the current byte pushed
    always_comb
    begin
        c_eff  = (data_byte == CH_NEL) ? CH_LF : data_byte;
        cnt_p  = (cnt_reg == LEN_MAX) ? cnt_reg : cnt_reg + 16'd1;
        head_p = head_reg;
        if (cnt_reg < 16'd6)
            head_p[{cnt_reg[2:0], 3'b000} +: 8] = c_eff;
        tail_p = {tail_reg[15:0], c_eff};
    end

    // Next state and results
    always_comb
    begin
        markup_next  = markup_reg;
        comment_next = comment_reg;
        cnt_next     = cnt_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        saw_next     = saw_reg;
        depth_next   = depth_reg;
        root_next    = root_reg;
        halt_next    = halt_reg;
        res_a        = '0;
        res_b        = '0;
        n_res        = 2'd0;
        halt_tmp     = 1'b0;
        comment_p    = comment_reg;
        fin          = finish_markup(cnt_p, head_p, tail_p, depth_reg, root_reg, DEPTH_LIMIT);

        if (!halt_reg)
        begin
            if (req_type)
            begin
                // End of document: flush pending segment, then check depth
                if (cnt_reg != 16'd0)
                begin
                    if (markup_reg)
                    begin
                        fin = finish_markup(cnt_reg, head_reg, tail_reg, depth_reg,
                                            root_reg, DEPTH_LIMIT);
                        res_a      = mk_res(fin.kind, fin.code, cnt_reg, fin.depth);
                        n_res      = 2'd1;
                        depth_next = fin.depth;
                        root_next  = fin.root;
                        halt_tmp   = (fin.code != ERR_NONE);
                    end
                    else if (saw_reg)
                    begin
                        res_a = mk_res(KIND_TEXT, ERR_NONE, cnt_reg, depth_reg);
                        n_res = 2'd1;
                    end
                end
                if (!halt_tmp && depth_next != 8'd0)
                begin
                    if (n_res == 2'd0)
                        res_a = mk_res(KIND_ERROR, ERR_MISSING_CLOSE, 16'd0, depth_next);
                    else
                        res_b = mk_res(KIND_ERROR, ERR_MISSING_CLOSE, 16'd0, depth_next);
                    n_res    = n_res + 2'd1;
                    halt_tmp = 1'b1;
                end
                if (halt_tmp)
                    halt_next = 1'b1;
                else
                begin
                    markup_next  = 1'b0;
                    comment_next = 1'b0;
                    cnt_next     = '0;
                    head_next    = '0;
                    tail_next    = '0;
                    saw_next     = 1'b0;
                    depth_next   = '0;
                    root_next    = 1'b0;
                end
            end
            else if (data_byte == CH_NEL && markup_reg)
            begin
                res_a     = mk_res(KIND_ERROR, ERR_BAD_CHAR, cnt_p, depth_reg);
                n_res     = 2'd1;
                halt_next = 1'b1;
            end
            else if (!markup_reg)
            begin
                if (c_eff == CH_LT)
                begin
                    // Close text, open markup
                    if (cnt_reg != 16'd0 && saw_reg)
                    begin
                        res_a = mk_res(KIND_TEXT, ERR_NONE, cnt_reg, depth_reg);
                        n_res = 2'd1;
                        if (depth_reg == 8'd0)
                            root_next = 1'b1;
                    end
                    cnt_next    = 16'd1;
                    head_next   = {40'd0, CH_LT};
                    tail_next   = {16'd0, CH_LT};
                    saw_next    = 1'b0;
                    markup_next = 1'b1;
                end
                else if (c_eff == CH_GT)
                begin
                    res_a     = mk_res(KIND_ERROR, ERR_STRAY_GT, cnt_p, depth_reg);
                    n_res     = 2'd1;
                    halt_next = 1'b1;
                end
                else
                begin
                    cnt_next  = cnt_p;
                    head_next = head_p;
                    tail_next = tail_p;
                    if (!is_space(c_eff))
                        saw_next = 1'b1;
                end
            end
            else if (c_eff == CH_GT)
            begin
                cnt_next  = cnt_p;
                head_next = head_p;
                tail_next = tail_p;
                if (comment_reg && cnt_p > 16'd2 && tail_p == TAIL_CMT)
                    comment_p = 1'b0;
                comment_next = comment_p;
                if (!comment_p)
                begin
                    res_a      = mk_res(fin.kind, fin.code, cnt_p, fin.depth);
                    n_res      = 2'd1;
                    depth_next = fin.depth;
                    root_next  = fin.root;
                    if (fin.code != ERR_NONE)
                        halt_next = 1'b1;
                    else
                    begin
                        cnt_next    = '0;
                        head_next   = '0;
                        tail_next   = '0;
                        saw_next    = 1'b0;
                        markup_next = 1'b0;
                    end
                end
            end
            else if (!comment_reg && c_eff == CH_LT)
            begin
                res_a     = mk_res(KIND_ERROR, ERR_STRAY_LT, cnt_p, depth_reg);
                n_res     = 2'd1;
                halt_next = 1'b1;
            end
            else
            begin
                cnt_next  = cnt_p;
                head_next = head_p;
                tail_next = tail_p;
                if (!comment_reg && cnt_p == 16'd4 && head_p[31:0] == HEAD_CMT)
                    comment_next = 1'b1;
            end
        end

        // Mark the last result of this request
        if (n_res == 2'd1)
            res_a.last_result = 1'b1;
        if (n_res == 2'd2)
            res_b.last_result = 1'b1;
    end

    assign step_out.count  = advance ? n_res : 2'd0;
    assign step_out.first  = res_a;
    assign step_out.second = res_b;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            markup_reg  <= 1'b0;
            comment_reg <= 1'b0;
            cnt_reg     <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            saw_reg     <= 1'b0;
            depth_reg   <= '0;
            root_reg    <= 1'b0;
            halt_reg    <= 1'b0;
        end
        else if (advance)
        begin
            markup_reg  <= markup_next;
            comment_reg <= comment_next;
            cnt_reg     <= cnt_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            saw_reg     <= saw_next;
            depth_reg   <= depth_next;
            root_reg    <= root_next;
            halt_reg    <= halt_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/xms_outq.sv
// Four-entry result queue: takes up to two results a cycle, hands out one while the sink is ready.
`default_nettype none

module xms_outq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  xms_pkg::step_out_t  step_in,
    output logic                space,
    xms_rsp_if.source           rsp
);
    import xms_pkg::*;

    localparam int DEPTH = 4;

    res_t       mem_reg [DEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] fill_reg, fill_next;
    logic       pop;
    res_t       head_res;

    assign pop   = rsp.valid && rsp.ready;
    assign space = (fill_reg <= 3'd2);

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + step_in.count;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        fill_next   = fill_reg + {1'b0, step_in.count} - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (step_in.count != 2'd0)
            mem_reg[wr_ptr_reg] <= step_in.first;
        if (step_in.count == 2'd2)
            mem_reg[wr_ptr_reg + 2'd1] <= step_in.second;
    end

    assign head_res        = mem_reg[rd_ptr_reg];
    assign rsp.valid       = (fill_reg != 3'd0);
    assign rsp.seg_kind    = head_res.seg_kind;
    assign rsp.error_code  = head_res.error_code;
    assign rsp.seg_length  = head_res.seg_length;
    assign rsp.depth_after = head_res.depth_after;
    assign rsp.last_result = head_res.last_result;

endmodule

`default_nettype wire

### hw/rtl/xml_markup_segmenter.sv
// Top level of the XML markup segmenter: input register, segment logic, result queue.
// Results of an accepted request are written into the result queue, which drives the result channel;
// the second result of an end-of-document request is handed out after the first.
// Throughput: one request per cycle; input waits only while the four-entry result
// queue holds three or more results, which happens when the sink stalls.
// Reset: asynchronous, active low; clears all segment state, depth and the error halt.
`default_nettype none

module xml_markup_segmenter #(
    parameter int unsigned MAX_DEPTH = xms_pkg::MAX_DEPTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    xms_req_if.sink     req,
    xms_rsp_if.source   rsp
);
    import xms_pkg::*;

    logic       in_valid_reg;
    logic       in_type_reg;
    logic [7:0] in_byte_reg;
    logic       space;
    logic       advance;
    step_out_t  step_out;

    assign advance   = in_valid_reg && space;
    assign req.ready = !in_valid_reg || advance;

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.ready)
            in_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_type_reg <= req.req_type;
            in_byte_reg <= req.data_byte;
        end
    end

    xms_core #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .req_type  (in_type_reg),
        .data_byte (in_byte_reg),
        .step_out  (step_out)
    );

    xms_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_in (step_out),
        .space   (space),
        .rsp     (rsp)
    );

endmodule

`default_nettype wire

### test/xml_markup_segmenter_tb.sv
// Self-checking testbench for the XML markup segmenter: scripted, extreme and random documents.
`timescale 1ns / 1ps

module xml_markup_segmenter_tb;
    import xms_pkg::*;

    localparam int unsigned TB_MAX_DEPTH   = 48;
    localparam int unsigned DEPTH_CAP      = (TB_MAX_DEPTH > 255) ? 255 : TB_MAX_DEPTH;
    localparam int          ITEM_TARGET    = 1200;
    localparam int          HOLD_OFF       = 400;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          PRINT_LIMIT    = 40;

    // Parser state mirrored by the predictor
    typedef struct packed {
        logic        markup_open;
        logic        comment_open;
        logic [15:0] seg_len;
        logic [47:0] head;
        logic [23:0] tail;
        logic        non_space;
        logic [7:0]  depth;
        logic        root_child;
        logic        halted;
    } seg_state_t;

    // One row of the opening script; typed rows carry the single result they must give
    typedef struct packed {
        logic        eod;
        logic [7:0]  data;
        logic        typed;
        seg_kind_t   kind;
        logic [15:0] len;
        logic [7:0]  depth;
    } script_row_t;

    logic clk;
    logic rst_n;

    xms_req_if req_ch ();
    xms_rsp_if rsp_ch ();

    xml_markup_segmenter #(
        .MAX_DEPTH (TB_MAX_DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    seg_state_t  doc_st;
    res_t        step_res[$];
    res_t        owed_segments[$];
    logic [7:0]  doc_bytes[$];
    int          mismatch_count;
    int          seg_seen;
    int          quiet_cycles;
    int          hold_off_cycles;
    bit          tx_idle_on;
    bit          rx_idle_on;

    // Reset-state document: declaration, element with odd text bytes, blank tail
    script_row_t opening_script [21] = '{
        '{1'b1, 8'h00, 1'b0, KIND_TEXT,  16'd0, 8'd0},
        '{1'b0, "<",   1'b0, KIND_TEXT,  16'd0, 8'd0},
        '{1'b0, "?",   1'b0, KIND_TEXT,  16'd0, 8'd0},
        '{1'b0, "x",   1'b0, KIND_TEXT,  16'd0, 8'd0},
        '{1'b0, "m",   1'b0, KIND_TEXT,  16'd0, 8'd0},
        '{1'b0, "l",   1'b0, KIND_TEXT,  16'd0, 8'd0},
        '{1'b0, " ",   1'b0, KIND_TEXT,  16'd0, 8'd0},
        '{1'b0, "?",   1'b0, KIND_TEXT,  16'd0, 8'd0},
        '{1'b0, ">",   1'b1, KIND_DECL,  16'd8, 8'd0},
        '{1'b0, "<",   1'b0, KIND_TEXT,  16'd0, 8'd0},
        '{1'b0, "a",   1'b0, KIND_TEXT,  16'd0, 8'd0},
        '{1'b0, ">",   1'b1, KIND_START, 16'd3, 8'd1},
        '{1'b0, 8'h85, 1'b0, KIND_TEXT,  16'd0, 8'd0},
        '{1'b0, 8'hFF, 1'b0, KIND_TEXT,  16'd0, 8'd0},
        '{1'b0, 8'h00, 1'b0, KIND_TEXT,  16'd0, 8'd0},
        '{1'b0, "<",   1'b1, KIND_TEXT,  16'd3, 8'd1},
        '{1'b0, "/",   1'b0, KIND_TEXT,  16'd0, 8'd0},
        '{1'b0, "a",   1'b0, KIND_TEXT,  16'd0, 8'd0},
        '{1'b0, ">",   1'b1, KIND_END,   16'd4, 8'd0},
        '{1'b0, 8'h09, 1'b0, KIND_TEXT,  16'd0, 8'd0},
        '{1'b1, 8'hA5, 1'b0, KIND_TEXT,  16'd0, 8'd0}
    };

    // ---------------------------------------------------------------- predictor

    function automatic bit head_has(string s);
        for (int i = 0; i < s.len(); i++)
            if (doc_st.head[8*i +: 8] != s[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Tail ends with s: the newest byte of the tail matches the last character of s
    function automatic bit tail_has(string s);
        for (int i = 0; i < s.len(); i++)
            if (doc_st.tail[8*(s.len()-1-i) +: 8] != s[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void add_byte(logic [7:0] c);
        if (doc_st.seg_len < 16'd6)
            doc_st.head[8*doc_st.seg_len +: 8] = c;
        doc_st.tail = {doc_st.tail[15:0], c};
        if (doc_st.seg_len != 16'hFFFF)
            doc_st.seg_len++;
    endfunction

    function automatic void clear_segment();
        doc_st.seg_len   = '0;
        doc_st.head      = '0;
        doc_st.tail      = '0;
        doc_st.non_space = 1'b0;
    endfunction

    // Queue one result; an error halts the parser
    function automatic void emit_segment(seg_kind_t kind, err_code_t code, logic [15:0] n);
        res_t r;
        r.seg_kind    = kind;
        r.error_code  = code;
        r.seg_length  = n;
        r.depth_after = doc_st.depth;
        r.last_result = 1'b0;
        step_res.push_back(r);
        if (kind == KIND_ERROR)
            doc_st.halted = 1'b1;
    endfunction

    function automatic void flush_text();
        if (doc_st.seg_len == 16'd0 || !doc_st.non_space)
            return;
        if (doc_st.depth == 8'd0)
            doc_st.root_child = 1'b1;
        emit_segment(KIND_TEXT, ERR_NONE, doc_st.seg_len);
    endfunction

    // Classify the pending markup and apply it to depth and root
    function automatic void close_markup();
        logic [15:0] n;
        seg_kind_t   kind;
        n = doc_st.seg_len;
        if (n >= 16'd7 && head_has("<!--") && tail_has("-->"))
            kind = KIND_COMMENT;
        else if (n >= 16'd7 && head_has("<?xml ") && tail_has("?>"))
            kind = KIND_DECL;
        else if (n >= 16'd4 && head_has("<?") && tail_has("?>"))
            kind = KIND_PI;
        else if (n >= 16'd3 && head_has("<") && tail_has("/>"))
            kind = KIND_EMPTY;
        else if (n >= 16'd3 && head_has("</") && tail_has(">"))
            kind = KIND_END;
        else if (n >= 16'd2 && head_has("<") && tail_has(">"))
            kind = KIND_START;
        else
        begin
            emit_segment(KIND_ERROR, ERR_INVALID_TAG, n);
            return;
        end

        case (kind)
            KIND_START:
            begin
                if (doc_st.depth >= DEPTH_CAP)
                begin
                    emit_segment(KIND_ERROR, ERR_TOO_DEEP, n);
                    return;
                end
                if (doc_st.depth == 8'd0)
                    doc_st.root_child = 1'b1;
                doc_st.depth++;
            end
            KIND_END:
            begin
                if (doc_st.depth == 8'd0)
                begin
                    emit_segment(KIND_ERROR, ERR_UNMATCHED_END, n);
                    return;
                end
                doc_st.depth--;
            end
            KIND_DECL:
            begin
                if (doc_st.depth != 8'd0)
                begin
                    emit_segment(KIND_ERROR, ERR_DECL_NESTED, n);
                    return;
                end
                if (doc_st.root_child)
                begin
                    emit_segment(KIND_ERROR, ERR_DECL_NOT_1ST, n);
                    return;
                end
            end
            default:
            begin
                if (doc_st.depth == 8'd0)
                    doc_st.root_child = 1'b1;
            end
        endcase
        emit_segment(kind, ERR_NONE, n);
    endfunction

    // Results caused by one request, left in step_res
    function automatic void step_segments(logic rt, logic [7:0] b);
        logic [7:0] c;
        c = b;
        step_res.delete();
        if (doc_st.halted)
            return;

        if (rt)
        begin
            // end of document: flush, check depth, start over unless halted
            if (doc_st.seg_len > 16'd0)
            begin
                if (doc_st.markup_open)
                    close_markup();
                else
                    flush_text();
            end
            if (!doc_st.halted && doc_st.depth != 8'd0)
                emit_segment(KIND_ERROR, ERR_MISSING_CLOSE, 16'd0);
            if (!doc_st.halted)
                doc_st = '0;
        end
        else if (c == 8'h85 && doc_st.markup_open)
        begin
            add_byte(c);
            emit_segment(KIND_ERROR, ERR_BAD_CHAR, doc_st.seg_len);
        end
        else
        begin
            if (c == 8'h85)
                c = 8'h0A;
            if (!doc_st.markup_open)
            begin
                if (c == "<")
                begin
                    flush_text();
                    clear_segment();
                    add_byte(c);
                    doc_st.markup_open = 1'b1;
                end
                else if (c == ">")
                begin
                    add_byte(c);
                    emit_segment(KIND_ERROR, ERR_STRAY_GT, doc_st.seg_len);
                end
                else
                begin
                    add_byte(c);
                    if (!(c inside {8'h20, 8'h09, 8'h0D, 8'h0A}))
                        doc_st.non_space = 1'b1;
                end
            end
            else if (c == ">")
            begin
                add_byte(c);
                if (doc_st.comment_open && doc_st.seg_len > 16'd2 && tail_has("-->"))
                    doc_st.comment_open = 1'b0;
                if (!doc_st.comment_open)
                begin
                    close_markup();
                    if (!doc_st.halted)
                    begin
                        clear_segment();
                        doc_st.markup_open = 1'b0;
                    end
                end
            end
            else if (!doc_st.comment_open && c == "<")
            begin
                add_byte(c);
                emit_segment(KIND_ERROR, ERR_STRAY_LT, doc_st.seg_len);
            end
            else
            begin
                add_byte(c);
                if (!doc_st.comment_open && doc_st.seg_len == 16'd4 && head_has("<!--"))
                    doc_st.comment_open = 1'b1;
            end
        end

        if (step_res.size() > 0)
            step_res[step_res.size()-1].last_result = 1'b1;
    endfunction

    // ---------------------------------------------------------------- document generation

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            doc_bytes.push_back(s[i]);
    endfunction

    function automatic logic [7:0] rand_markup_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == "<" || c == ">" || c == 8'h85);
        return c;
    endfunction

    function automatic logic [7:0] rand_text_byte();
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0: c = 8'h20;
            1: c = 8'h09;
            2: c = 8'h0D;
            3: c = 8'h0A;
            4: c = 8'h85;
            default:
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == "<" || c == ">");
            end
        endcase
        return c;
    endfunction

    // Tag name bytes; no trailing '/', and a start tag does not open with '/' or '?'
    function automatic void add_tag_name(int n, bit open_tag);
        logic [7:0] c;
        for (int i = 0; i < n; i++)
        begin
            do
                c = rand_markup_byte();
            while ((i == n - 1 && c == "/") ||
                   (open_tag && i == 0 && (c == "/" || c == "?")));
            doc_bytes.push_back(c);
        end
    endfunction

    // Dry run of the current document on a copy of the parser state
    function automatic bit document_is_clean();
        seg_state_t saved;
        bit         clean;
        saved = doc_st;
        foreach (doc_bytes[i])
            step_segments(1'b0, doc_bytes[i]);
        step_segments(1'b1, 8'h00);
        clean = !doc_st.halted;
        doc_st = saved;
        return clean;
    endfunction

    // Well-formed document with random content, sometimes with one byte changed
    function automatic void build_document();
        int         budget;
        int         open;
        int         pick;
        int         pos;
        logic [7:0] keep;
        logic [7:0] c;
        do
        begin
            doc_bytes.delete();
            budget = $urandom_range(6, 90);
            open   = 0;
            if ($urandom_range(0, 3) == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    doc_bytes.push_back(8'h0A);
                add_text("<?xml ");
                add_tag_name($urandom_range(0, 4), 1'b0);
                add_text("?>");
            end
            while (doc_bytes.size() < budget || open > 0)
            begin
                pick = (doc_bytes.size() >= budget) ? 3 : $urandom_range(0, 9);
                case (pick)
                    0, 1, 2:
                    begin
                        add_text("<");
                        add_tag_name($urandom_range(0, 4), 1'b1);
                        add_text(">");
                        open++;
                    end
                    3, 4:
                    begin
                        if (open > 0)
                        begin
                            add_text("</");
                            add_tag_name($urandom_range(1, 4), 1'b0);
                            add_text(">");
                            open--;
                        end
                    end
                    5:
                    begin
                        add_text("<");
                        add_tag_name($urandom_range(0, 3), 1'b0);
                        add_text("/>");
                    end
                    6:
                    begin
                        // comment body may hold '<' and '>'
                        add_text("<!--");
                        repeat ($urandom_range(0, 8))
                        begin
                            do
                                c = 8'($urandom_range(0, 255));
                            while (c == 8'h85 || c == "-");
                            doc_bytes.push_back(c);
                        end
                        add_text("-->");
                    end
                    7:
                    begin
                        add_text("<?");
                        add_tag_name($urandom_range(0, 4), 1'b0);
                        add_text("?>");
                    end
                    default:
                    begin
                        repeat (($urandom_range(0, 15) == 0) ? $urandom_range(200, 600)
                                                             : $urandom_range(1, 12))
                            doc_bytes.push_back(rand_text_byte());
                    end
                endcase
            end
        end
        while (!document_is_clean());

        // a stray byte is kept only when the document still parses without error
        if ($urandom_range(0, 4) == 0)
        begin
            pos  = $urandom_range(0, doc_bytes.size() - 1);
            keep = doc_bytes[pos];
            doc_bytes[pos] = 8'($urandom_range(0, 255));
            if (!document_is_clean())
                doc_bytes[pos] = keep;
        end
    endfunction

    // Short document that ends in the given error
    function automatic void build_fault(err_code_t code);
        doc_bytes.delete();
        case (code)
            ERR_BAD_CHAR:
            begin
                add_text("<a");
                doc_bytes.push_back(8'h85);
            end
            ERR_STRAY_GT:      add_text("ab>");
            ERR_STRAY_LT:      add_text("<a<");
            ERR_UNMATCHED_END: add_text("</a>");
            ERR_DECL_NESTED:   add_text("<r><?xml ?>");
            ERR_DECL_NOT_1ST:  add_text("<!----> <?xml v?>");
            ERR_INVALID_TAG:   add_text("<r><!-");
            ERR_MISSING_CLOSE: add_text("<r>zz");
            default:           repeat (DEPTH_CAP + 1) add_text("<>");
        endcase
    endfunction

    // ---------------------------------------------------------------- request driver

    // Offer one request, wait for it to be taken, record what it owes
    task automatic apply_request(logic rt, logic [7:0] b, logic typed, res_t typed_seg);
        int gap;
        if (tx_idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 10);
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= rt;
        req_ch.data_byte <= b;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        step_segments(rt, b);
        if (typed)
            owed_segments.push_back(typed_seg);
        else
            foreach (step_res[i])
                owed_segments.push_back(step_res[i]);
    endtask

    task automatic send_document(inout int sent);
        foreach (doc_bytes[i])
            apply_request(1'b0, doc_bytes[i], 1'b0, '0);
        apply_request(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
        sent += doc_bytes.size() + 1;
    endtask

    // ---------------------------------------------------------------- clock, sink, checks

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Result sink: long hold-off on request, else random stall bursts
    initial
    begin
        int burst;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                burst = hold_off_cycles;
                hold_off_cycles = 0;
                rsp_ch.ready <= 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 10);
                rsp_ch.ready <= 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t ns: segment %0d: %s is %0d, predicted %0d",
                     $time, seg_seen, what, got, want);
    endtask

    // Compare each taken result with the oldest prediction
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (owed_segments.size() == 0)
                report_mismatch("unpredicted segment, kind", rsp_ch.seg_kind, -1);
            else
            begin
                want = owed_segments.pop_front();
                if (rsp_ch.seg_kind != want.seg_kind)
                    report_mismatch("seg_kind", rsp_ch.seg_kind, want.seg_kind);
                if (rsp_ch.error_code != want.error_code)
                    report_mismatch("error_code", rsp_ch.error_code, want.error_code);
                if (rsp_ch.seg_length != want.seg_length)
                    report_mismatch("seg_length", rsp_ch.seg_length, want.seg_length);
                if (rsp_ch.depth_after != want.depth_after)
                    report_mismatch("depth_after", rsp_ch.depth_after, want.depth_after);
                if (rsp_ch.last_result != want.last_result)
                    report_mismatch("last_result", rsp_ch.last_result, want.last_result);
            end
            seg_seen++;
        end
    end

    // Watchdog on cycles where neither channel moves
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("xml_markup_segmenter_tb: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin
        script_row_t row;
        res_t        row_seg;
        int          sent;

        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = 1'b0;
        req_ch.data_byte = 8'h00;
        rsp_ch.ready     = 1'b0;
        doc_st           = '0;
        mismatch_count   = 0;
        seg_seen         = 0;
        quiet_cycles     = 0;
        hold_off_cycles  = 0;
        tx_idle_on       = 1'b1;
        rx_idle_on       = 1'b1;
        sent             = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // opening script
        foreach (opening_script[i])
        begin
            row = opening_script[i];
            row_seg = '0;
            row_seg.seg_kind    = row.kind;
            row_seg.seg_length  = row.len;
            row_seg.depth_after = row.depth;
            row_seg.last_result = 1'b1;
            apply_request(row.eod, row.data, row.typed, row_seg);
            sent++;
        end

        // deepest legal nesting, then back out
        doc_bytes.delete();
        repeat (DEPTH_CAP) add_text("<>");
        add_text("deep");
        repeat (DEPTH_CAP) add_text("</d>");
        send_document(sent);

        // random documents; the first runs into a long sink hold-off
        tx_idle_on      = 1'b0;
        rx_idle_on      = 1'b0;
        hold_off_cycles = HOLD_OFF;
        while (sent < ITEM_TARGET)
        begin
            build_document();
            send_document(sent);
            tx_idle_on = (sent < ITEM_TARGET * 4 / 5) && ($urandom_range(0, 2) != 0);
            rx_idle_on = (sent < ITEM_TARGET * 4 / 5) && ($urandom_range(0, 2) != 0);
        end

        // one error to finish, then requests that a halted parser must swallow
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        build_fault(err_code_t'($urandom_range(1, 9)));
        send_document(sent);
        repeat (30)
            apply_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 1'b0, '0);
        @(negedge clk);
        req_ch.valid <= 1'b0;

        while (owed_segments.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("xml_markup_segmenter_tb: PASS");
        else
            $display("xml_markup_segmenter_tb: FAIL");
        $finish;
    end

endmodule
